// ===== hdl/smx_pkg.sv =====
// Shared types and constants for the stack machine execute unit.
// No dependencies.
package smx_pkg;

   localparam int DATA_DEPTH_DEF = 64;
   localparam int CALL_DEPTH_DEF = 16;
   localparam int NUM_REGS_DEF   = 4;
   localparam int PC_WIDTH_DEF   = 10;

   localparam int DATA_W   = 32;
   localparam int OP_W     = 5;
   localparam int RIDX_W   = 2;
   localparam int TGT_W    = 10;
   localparam int OPC_W    = 11;   // next_pc and program_length port width
   localparam int ERR_W    = 3;

   localparam logic [OP_W-1:0] OP_BEGIN = 5'd0;
   localparam logic [OP_W-1:0] OP_END   = 5'd1;
   localparam logic [OP_W-1:0] OP_POP   = 5'd2;
   localparam logic [OP_W-1:0] OP_ADD   = 5'd3;
   localparam logic [OP_W-1:0] OP_SUB   = 5'd4;
   localparam logic [OP_W-1:0] OP_MUL   = 5'd5;
   localparam logic [OP_W-1:0] OP_DIV   = 5'd6;
   localparam logic [OP_W-1:0] OP_OUT   = 5'd7;
   localparam logic [OP_W-1:0] OP_NPOUT = 5'd8;
   localparam logic [OP_W-1:0] OP_IN    = 5'd9;
   localparam logic [OP_W-1:0] OP_RET   = 5'd10;
   localparam logic [OP_W-1:0] OP_PUSH  = 5'd11;
   localparam logic [OP_W-1:0] OP_PUSHR = 5'd12;
   localparam logic [OP_W-1:0] OP_POPR  = 5'd13;
   localparam logic [OP_W-1:0] OP_JMP   = 5'd14;
   localparam logic [OP_W-1:0] OP_JEQ   = 5'd15;
   localparam logic [OP_W-1:0] OP_JNE   = 5'd16;
   localparam logic [OP_W-1:0] OP_JA    = 5'd17;
   localparam logic [OP_W-1:0] OP_JAE   = 5'd18;
   localparam logic [OP_W-1:0] OP_JB    = 5'd19;
   localparam logic [OP_W-1:0] OP_JBE   = 5'd20;
   localparam logic [OP_W-1:0] OP_CALL  = 5'd21;

   localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
   localparam logic [ERR_W-1:0] ERR_DATA_UNDER = 3'd1;
   localparam logic [ERR_W-1:0] ERR_DATA_OVER = 3'd2;
   localparam logic [ERR_W-1:0] ERR_DIV_ZERO  = 3'd3;
   localparam logic [ERR_W-1:0] ERR_CALL_UNDER = 3'd4;
   localparam logic [ERR_W-1:0] ERR_CALL_OVER = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_WB
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== hdl/smx_if.sv =====
// Handshake channels of the stack machine execute unit: instruction and result.
// Depends on smx_pkg.
interface smx_req_if import smx_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [DATA_W-1:0] immediate;
   logic [RIDX_W-1:0] reg_index;
   logic [TGT_W-1:0]  jump_target;
   logic [DATA_W-1:0] console_value;

   modport source (output valid, opcode, immediate, reg_index, jump_target,
                   console_value, input ready);
   modport sink   (input valid, opcode, immediate, reg_index, jump_target,
                   console_value, output ready);
endinterface

interface smx_rsp_if import smx_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OPC_W-1:0]  next_pc;
   logic [DATA_W-1:0] print_value;
   logic              print_valid;
   logic              halted;
   logic [ERR_W-1:0]  error_code;

   modport source (output valid, next_pc, print_value, print_valid, halted,
                   error_code, input ready);
   modport sink   (input valid, next_pc, print_value, print_valid, halted,
                   error_code, output ready);
endinterface

// ===== hdl/smx_data_ram.sv =====
// Data stack memory: one write port, two registered read ports.
// Depends on smx_pkg.
module smx_data_ram
   import smx_pkg::*;
#(
   parameter int DEPTH = DATA_DEPTH_DEF,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [AW-1:0]     waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [AW-1:0]     raddr_a,
   input  logic [AW-1:0]     raddr_b,
   output logic [DATA_W-1:0] rdata_a,
   output logic [DATA_W-1:0] rdata_b
);
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_a_ff;
   logic [DATA_W-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_a_ff <= mem[raddr_a];
         rdata_b_ff <= mem[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;
endmodule

// ===== hdl/smx_divider.sv =====
// Signed truncating divider, one quotient bit per cycle (restoring).
// Depends on smx_pkg.
module smx_divider
   import smx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);
   localparam int CW = $clog2(DATA_W + 1);

   logic [CW-1:0]     count_ff, count_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dsr_ff, dsr_in;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   shifted;

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      shifted  = {rem_ff, quo_ff[DATA_W-1]};
      trial    = shifted - {1'b0, dsr_ff};
      if (div_req.start) begin
         busy_in  = 1'b1;
         done_in  = 1'b0;
         count_in = CW'(DATA_W);
         neg_in   = div_req.dividend[DATA_W-1] ^ div_req.divisor[DATA_W-1];
         rem_in   = '0;
         quo_in   = div_req.dividend[DATA_W-1] ? (DATA_W'(0) - div_req.dividend)
                                               : div_req.dividend;
         dsr_in   = div_req.divisor[DATA_W-1] ? (DATA_W'(0) - div_req.divisor)
                                              : div_req.divisor;
      end else if (busy_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? (DATA_W'(0) - quo_ff) : quo_ff;
endmodule

// ===== hdl/stack_machine_execute_unit.sv =====
// Stack machine execute unit: one instruction per req beat, one rsp beat each.
// Result registered at commit; divide goes through the 32-step divider, then writeback.
// New instructions are accepted only in the idle state, after the last one commits.
// Reset (synchronous, active high) clears depths, registers, pc, halt, length.
// Stack memory contents are not cleared. Depends on smx_pkg, smx_if, RAM, divider.
module stack_machine_execute_unit
   import smx_pkg::*;
#(
   parameter int DATA_DEPTH = DATA_DEPTH_DEF,
   parameter int CALL_DEPTH = CALL_DEPTH_DEF,
   parameter int NUM_REGS   = NUM_REGS_DEF,
   parameter int PC_WIDTH   = PC_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   smx_req_if.sink          req_bus,
   smx_rsp_if.source        rsp_bus,
   input  logic             csr_wr_en,
   input  logic [OPC_W-1:0] csr_wr_data
);
   localparam int DAW = $clog2(DATA_DEPTH);
   localparam int DDW = $clog2(DATA_DEPTH + 1);
   localparam int RAW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
   localparam int RDW = $clog2(CALL_DEPTH + 1);
   localparam int RIW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int PCW = PC_WIDTH + 1;

   // sequencer
   state_type state_ff, state_in;
   logic      accept, commit, out_free;

   // architectural state
   logic [DDW-1:0]      ddep_ff, ddep_in;
   logic [RDW-1:0]      rdep_ff, rdep_in;
   logic [PCW-1:0]      pc_ff, pc_in;
   logic                halt_ff, halt_in;
   logic [OPC_W-1:0]    plen_ff;
   logic [DATA_W-1:0]   gpr_ff [NUM_REGS];

   // latched instruction
   logic [OP_W-1:0]     op_ff;
   logic [DATA_W-1:0]   imm_ff;
   logic [RIDX_W-1:0]   ridx_ff;
   logic [TGT_W-1:0]    tgt_ff;
   logic [DATA_W-1:0]   con_ff;

   // memories
   logic [DATA_W-1:0]   top_val, sec_val;
   logic                ds_we;
   logic [DAW-1:0]      ds_waddr;
   logic [DATA_W-1:0]   ds_wdata;
   logic [PC_WIDTH-1:0] rs_mem [CALL_DEPTH];
   logic [PC_WIDTH-1:0] rs_rd_ff;
   logic                rs_we;

   // result register
   logic                rsp_valid_ff;
   logic [OPC_W-1:0]    rsp_pc_ff;
   logic [DATA_W-1:0]   rsp_pv_ff;
   logic                rsp_pvalid_ff;
   logic                rsp_halt_ff;
   logic [ERR_W-1:0]    rsp_err_ff;

   // execute results
   logic [ERR_W-1:0]    err;
   logic [DATA_W-1:0]   pv;
   logic                pvalid;
   logic                ended;
   logic [PCW-1:0]      pc_sel;
   logic                gpr_we;
   logic                ridx_ok;
   logic                is_pop1, is_pop2, is_push;
   logic signed [DATA_W-1:0] lval, rval;
   logic                taken;
   logic [DATA_W-1:0]   prod;
   logic                need_div;

   div_req_type div_req;
   div_rsp_type div_rsp;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign accept   = req_bus.valid && req_bus.ready;
   assign lval     = sec_val;
   assign rval     = top_val;
   assign prod     = top_val * sec_val;
   assign ridx_ok  = {{(DATA_W-RIDX_W){1'b0}}, ridx_ff} < DATA_W'(NUM_REGS);

   // Data stack: top at depth-1, second at depth-2; read on accept.
   smx_data_ram #(.DEPTH(DATA_DEPTH)) u_data_ram (
      .clock   (clock),
      .we      (ds_we),
      .waddr   (ds_waddr),
      .wdata   (ds_wdata),
      .re      (accept),
      .raddr_a (DAW'(ddep_ff - 1'b1)),
      .raddr_b (DAW'(ddep_ff - 2'd2)),
      .rdata_a (top_val),
      .rdata_b (sec_val)
   );

   smx_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Return stack: read at depth-1 on accept, written by call at commit.
   always_ff @(posedge clock) begin
      if (rs_we) begin
         rs_mem[rdep_ff[RAW-1:0]] <= pc_ff[PC_WIDTH-1:0];
      end
      if (accept) begin
         rs_rd_ff <= rs_mem[RAW'(rdep_ff - 1'b1)];
      end
   end

   // Decode, fault checks and next-state values of the instruction.
   always_comb begin
      is_pop1 = (op_ff == OP_POP) || (op_ff == OP_OUT) || (op_ff == OP_NPOUT) ||
                (op_ff == OP_POPR);
      is_pop2 = ((op_ff >= OP_ADD) && (op_ff <= OP_DIV)) ||
                ((op_ff >= OP_JEQ) && (op_ff <= OP_JBE));
      is_push = (op_ff == OP_IN) || (op_ff == OP_PUSH) || (op_ff == OP_PUSHR);

      priority if (is_pop1 && (ddep_ff == '0))               err = ERR_DATA_UNDER;
      else if (is_pop2 && (ddep_ff < DDW'(2)))               err = ERR_DATA_UNDER;
      else if (is_push && (ddep_ff == DDW'(DATA_DEPTH)))     err = ERR_DATA_OVER;
      else if ((op_ff == OP_DIV) && (top_val == '0))         err = ERR_DIV_ZERO;
      else if ((op_ff == OP_RET) && (rdep_ff == '0))         err = ERR_CALL_UNDER;
      else if ((op_ff == OP_CALL) && (rdep_ff == RDW'(CALL_DEPTH))) err = ERR_CALL_OVER;
      else                                                   err = ERR_NONE;

      unique case (op_ff)
         OP_JEQ:  taken = (lval == rval);
         OP_JNE:  taken = (lval != rval);
         OP_JA:   taken = (lval > rval);
         OP_JAE:  taken = (lval >= rval);
         OP_JB:   taken = (lval < rval);
         default: taken = (lval <= rval);
      endcase

      need_div = !halt_ff && (err == ERR_NONE) && (op_ff == OP_DIV);

      pv       = '0;
      pvalid   = 1'b0;
      ended    = 1'b0;
      pc_sel   = pc_ff;
      halt_in  = halt_ff;
      ddep_in  = ddep_ff;
      rdep_in  = rdep_ff;
      ds_we    = 1'b0;
      ds_waddr = DAW'(ddep_ff);
      ds_wdata = imm_ff;
      rs_we    = 1'b0;
      gpr_we   = 1'b0;

      if (!halt_ff && (err == ERR_NONE)) begin
         unique case (op_ff)
            OP_END: begin
               pc_sel  = PCW'(plen_ff);
               halt_in = 1'b1;
               ended   = 1'b1;
            end
            OP_POP: ddep_in = ddep_ff - 1'b1;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
               ds_we    = 1'b1;
               ds_waddr = DAW'(ddep_ff - 2'd2);
               ddep_in  = ddep_ff - 1'b1;
               if (op_ff == OP_ADD)      ds_wdata = sec_val + top_val;
               else if (op_ff == OP_SUB) ds_wdata = sec_val - top_val;
               else if (op_ff == OP_MUL) ds_wdata = prod;
               else                      ds_wdata = div_rsp.quotient;
            end
            OP_OUT: begin
               pv      = top_val;
               pvalid  = 1'b1;
               ddep_in = ddep_ff - 1'b1;
            end
            OP_NPOUT: begin
               pv     = top_val;
               pvalid = 1'b1;
            end
            OP_IN, OP_PUSH, OP_PUSHR: begin
               ds_we   = 1'b1;
               ddep_in = ddep_ff + 1'b1;
               if (op_ff == OP_IN)        ds_wdata = con_ff;
               else if (op_ff == OP_PUSH) ds_wdata = imm_ff;
               else                       ds_wdata = ridx_ok ? gpr_ff[RIW'(ridx_ff)] : '0;
            end
            OP_RET: begin
               rdep_in = rdep_ff - 1'b1;
               pc_sel  = PCW'(rs_rd_ff);
            end
            OP_POPR: begin
               gpr_we  = ridx_ok;
               ddep_in = ddep_ff - 1'b1;
            end
            OP_JMP: pc_sel = PCW'(PC_WIDTH'(tgt_ff));
            OP_JEQ, OP_JNE, OP_JA, OP_JAE, OP_JB, OP_JBE: begin
               ddep_in = ddep_ff - 2'd2;
               if (taken) pc_sel = PCW'(PC_WIDTH'(tgt_ff));
            end
            OP_CALL: begin
               rs_we   = 1'b1;
               rdep_in = rdep_ff + 1'b1;
               pc_sel  = PCW'(PC_WIDTH'(tgt_ff));
            end
            default: ;
         endcase
      end

      if (halt_ff)    pc_in = pc_ff;
      else if (ended) pc_in = pc_sel;
      else            pc_in = pc_sel + 1'b1;

      // memory and register writes only land on the commit cycle
      ds_we  = ds_we && commit;
      rs_we  = rs_we && commit;
      gpr_we = gpr_we && commit;
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: begin
            if (need_div)      state_in = ST_DIV;
            else if (out_free) state_in = ST_IDLE;
         end
         ST_DIV:  if (div_rsp.done) state_in = ST_WB;
         ST_WB:   if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_bus.ready     = 1'b0;
      commit            = 1'b0;
      div_req.start     = 1'b0;
      div_req.dividend  = sec_val;
      div_req.divisor   = top_val;
      unique case (state_ff)
         ST_IDLE: req_bus.ready = 1'b1;
         ST_EXEC: begin
            div_req.start = need_div;
            commit        = !need_div && out_free;
         end
         ST_DIV:  ;
         ST_WB:   commit = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ddep_ff      <= '0;
         rdep_ff      <= '0;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
         plen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) begin
            gpr_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            plen_ff <= csr_wr_data;
         end
         if (commit) begin
            ddep_ff <= ddep_in;
            rdep_ff <= rdep_in;
            pc_ff   <= pc_in;
            halt_ff <= halt_in;
         end
         if (gpr_we) begin
            gpr_ff[RIW'(ridx_ff)] <= top_val;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_bus.opcode;
         imm_ff  <= req_bus.immediate;
         ridx_ff <= req_bus.reg_index;
         tgt_ff  <= req_bus.jump_target;
         con_ff  <= req_bus.console_value;
      end
      if (commit) begin
         rsp_pc_ff     <= OPC_W'(pc_in);
         rsp_pv_ff     <= pv;
         rsp_pvalid_ff <= pvalid;
         rsp_halt_ff   <= halt_in;
         rsp_err_ff    <= halt_ff ? ERR_NONE : err;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.next_pc     = rsp_pc_ff;
   assign rsp_bus.print_value = rsp_pv_ff;
   assign rsp_bus.print_valid = rsp_pvalid_ff;
   assign rsp_bus.halted      = rsp_halt_ff;
   assign rsp_bus.error_code  = rsp_err_ff;

   // stack depths stay within their stores
   a_ddep_bound: assert property (@(posedge clock) disable iff (reset)
      ddep_ff <= DDW'(DATA_DEPTH)) else $error("data depth beyond stack");
   a_rdep_bound: assert property (@(posedge clock) disable iff (reset)
      rdep_ff <= RDW'(CALL_DEPTH)) else $error("call depth beyond stack");
   // halt is sticky until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff) else $error("halt flag dropped");
   // divider never started on a zero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (div_req.divisor != '0)) else $error("divide by zero issued");
   // a commit never overwrites a result still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      commit |-> (!rsp_valid_ff || rsp_bus.ready)) else $error("result overrun");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for stack_machine_execute_unit: directed table, then random programs.
// Depends on smx_pkg, smx_req_if/smx_rsp_if and the execute unit RTL.
module testbench;
   import smx_pkg::*;

   localparam int STACK_MAX  = 64;
   localparam int CALLS_MAX  = 16;
   localparam int REG_COUNT  = 4;
   localparam int DRAIN_WAIT = 60;       // covers the divide path
   localparam int CYCLE_CAP  = 400000;
   localparam logic [OP_W-1:0] OP_NOP = 5'd22;
   localparam logic [DATA_W-1:0] MIN_INT = 32'h8000_0000;
   localparam logic [DATA_W-1:0] MAX_INT = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] imm;
      logic [RIDX_W-1:0] ridx;
      logic [TGT_W-1:0]  tgt;
      logic [DATA_W-1:0] con;
   } instr_type;

   typedef struct packed {
      logic [OPC_W-1:0]  npc;
      logic [DATA_W-1:0] pval;
      logic              pvalid;
      logic              halted;
      logic [ERR_W-1:0]  err;
   } outcome_type;

   // directed row: instruction, plus a hand-typed outcome where it is obvious
   typedef struct packed {
      instr_type   ins;
      logic        typed;
      outcome_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [OPC_W-1:0] csr_wr_data = '0;

   smx_req_if req_bus ();
   smx_rsp_if rsp_bus ();

   stack_machine_execute_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus.sink),
      .rsp_bus     (rsp_bus.source),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------
   // Machine shadow: the state the block should hold after each beat.
   // ---------------------------------------------------------------
   logic [DATA_W-1:0] vm_stack [STACK_MAX];
   int                vm_depth = 0;
   logic [TGT_W-1:0]  vm_rets [CALLS_MAX];
   int                vm_rdepth = 0;
   logic [DATA_W-1:0] vm_regs [REG_COUNT] = '{default: '0};
   logic [OPC_W-1:0]  vm_pc = '0;
   logic              vm_halt = 1'b0;
   logic [OPC_W-1:0]  vm_length = '0;

   outcome_type pending_results [$];
   int  fail_count = 0;
   bit  quiet = 0;          // last part of the run: no idling on either side
   int  long_hold_req = 0;  // receiver stall length asked for by the sender

   function automatic logic [DATA_W-1:0] quot_trunc(logic [DATA_W-1:0] a,
                                                    logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q  = ma / mb;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   // signed compare of second-from-top (l) against top (r)
   function automatic bit branch_taken(logic [OP_W-1:0] op, logic [DATA_W-1:0] l,
                                       logic [DATA_W-1:0] r);
      case (op)
         OP_JEQ:  return $signed(l) == $signed(r);
         OP_JNE:  return $signed(l) != $signed(r);
         OP_JA:   return $signed(l) >  $signed(r);
         OP_JAE:  return $signed(l) >= $signed(r);
         OP_JB:   return $signed(l) <  $signed(r);
         default: return $signed(l) <= $signed(r);
      endcase
   endfunction

   // Executes one instruction on the shadow machine, returns the outcome.
   function automatic outcome_type execute_instr(instr_type ins);
      outcome_type o;
      logic [DATA_W-1:0] top, nxt;
      logic [OPC_W-1:0] pc;
      int d;
      bit pop1, pop2, push1, ended;
      o = '0;
      pc = vm_pc;
      d = vm_depth;
      ended = 0;
      if (!vm_halt) begin
         pop1  = ins.op inside {OP_POP, OP_OUT, OP_NPOUT, OP_POPR};
         pop2  = (ins.op >= OP_ADD && ins.op <= OP_DIV) ||
                 (ins.op >= OP_JEQ && ins.op <= OP_JBE);
         push1 = ins.op inside {OP_IN, OP_PUSH, OP_PUSHR};
         top = (d >= 1) ? vm_stack[d-1] : '0;
         nxt = (d >= 2) ? vm_stack[d-2] : '0;
         if (pop1 && d < 1)                            o.err = ERR_DATA_UNDER;
         else if (pop2 && d < 2)                       o.err = ERR_DATA_UNDER;
         else if (push1 && d >= STACK_MAX)             o.err = ERR_DATA_OVER;
         else if (ins.op == OP_DIV && top == 0)        o.err = ERR_DIV_ZERO;
         else if (ins.op == OP_RET && vm_rdepth == 0)  o.err = ERR_CALL_UNDER;
         else if (ins.op == OP_CALL && vm_rdepth >= CALLS_MAX)
            o.err = ERR_CALL_OVER;
         if (o.err == ERR_NONE) begin
            case (ins.op)
               OP_END: begin
                  pc = vm_length; vm_halt = 1'b1; ended = 1;
               end
               OP_POP: vm_depth = d - 1;
               OP_ADD: begin vm_stack[d-2] = nxt + top; vm_depth = d - 1; end
               OP_SUB: begin vm_stack[d-2] = nxt - top; vm_depth = d - 1; end
               OP_MUL: begin vm_stack[d-2] = nxt * top; vm_depth = d - 1; end
               OP_DIV: begin vm_stack[d-2] = quot_trunc(nxt, top); vm_depth = d - 1; end
               OP_OUT: begin o.pval = top; o.pvalid = 1'b1; vm_depth = d - 1; end
               OP_NPOUT: begin o.pval = top; o.pvalid = 1'b1; end
               OP_IN: begin vm_stack[d] = ins.con; vm_depth = d + 1; end
               OP_RET: begin vm_rdepth--; pc = {1'b0, vm_rets[vm_rdepth]}; end
               OP_PUSH: begin vm_stack[d] = ins.imm; vm_depth = d + 1; end
               OP_PUSHR: begin vm_stack[d] = vm_regs[ins.ridx]; vm_depth = d + 1; end
               OP_POPR: begin vm_regs[ins.ridx] = top; vm_depth = d - 1; end
               OP_JMP: pc = {1'b0, ins.tgt};
               OP_JEQ, OP_JNE, OP_JA, OP_JAE, OP_JB, OP_JBE: begin
                  vm_depth = d - 2;
                  if (branch_taken(ins.op, nxt, top)) pc = {1'b0, ins.tgt};
               end
               OP_CALL: begin
                  vm_rets[vm_rdepth] = pc[TGT_W-1:0];
                  vm_rdepth++;
                  pc = {1'b0, ins.tgt};
               end
               default: ;   // begin, nop and unused opcodes
            endcase
         end
         if (!ended) pc = pc + 1'b1;
         vm_pc = pc;
      end
      o.npc = vm_pc;
      o.halted = vm_halt;
      return o;
   endfunction

   // ---------------------------------------------------------------
   // Directed table. Typed outcomes only where obvious from reset state.
   // ---------------------------------------------------------------
   function automatic row_type mk(logic [OP_W-1:0] op, logic [DATA_W-1:0] imm = '0,
                                  logic [RIDX_W-1:0] ridx = '0, logic [TGT_W-1:0] tgt = '0,
                                  logic [DATA_W-1:0] con = '0, logic typed = 0,
                                  logic [OPC_W-1:0] npc = '0, logic [ERR_W-1:0] err = '0,
                                  logic [DATA_W-1:0] pval = '0, logic pvalid = 0);
      row_type r;
      r.ins = '{op, imm, ridx, tgt, con};
      r.typed = typed;
      r.want = '{npc, pval, pvalid, 1'b0, err};
      return r;
   endfunction

   row_type directed [$];

   initial begin
      directed = '{
         mk(OP_POP,   0, 0, 0, 0, 1, 11'd1, ERR_DATA_UNDER),
         mk(OP_ADD,   0, 0, 0, 0, 1, 11'd2, ERR_DATA_UNDER),
         mk(OP_RET,   0, 0, 0, 0, 1, 11'd3, ERR_CALL_UNDER),
         mk(OP_PUSH,  MIN_INT, 0, 0, 0, 1, 11'd4, ERR_NONE),
         mk(OP_PUSH,  32'hFFFF_FFFF, 0, 0, 0, 1, 11'd5, ERR_NONE),
         mk(OP_DIV),                         // most negative over -1 wraps
         mk(OP_NPOUT, 0, 0, 0, 0, 1, 11'd7, ERR_NONE, MIN_INT, 1'b1),
         mk(OP_PUSH,  0, 0, 0, 0, 1, 11'd8, ERR_NONE),
         mk(OP_DIV,   0, 0, 0, 0, 1, 11'd9, ERR_DIV_ZERO),
         mk(OP_PUSH,  MAX_INT),
         mk(OP_MUL),
         mk(OP_OUT),
         mk(OP_PUSHR, 0, 2'd3),
         mk(OP_POPR,  0, 2'd0),
         mk(OP_IN,    0, 0, 0, 32'hFFFF_FFFF),
         mk(OP_PUSHR, 0, 2'd0),
         mk(OP_JEQ,   0, 0, 10'h3FF),
         mk(OP_CALL,  0, 0, 10'h3FF),
         mk(OP_RET),
         mk(OP_JMP,   0, 0, 10'h000),
         mk(OP_NOP),
         mk(5'd31,    32'hFFFF_FFFF, 2'd3, 10'h3FF, 32'hFFFF_FFFF),
         mk(OP_BEGIN),
         mk(OP_SUB),
         mk(OP_PUSH,  32'd7)
      };
   end

   // ---------------------------------------------------------------
   // Random program generator, biased by the shadow stack depth.
   // Bursts of pushes or calls drive the stacks into overflow.
   // ---------------------------------------------------------------
   int burst_left = 0;
   logic [OP_W-1:0] burst_op;

   function automatic logic [DATA_W-1:0] pick_value();
      int k;
      k = $urandom_range(0, 9);
      if (k < 3) return $signed($urandom_range(0, 6)) - 3;
      if (k == 3) return $urandom_range(0, 1) ? MIN_INT : MAX_INT;
      return $urandom;
   endfunction

   function automatic instr_type random_instr();
      instr_type ins;
      int k;
      ins.imm  = pick_value();
      ins.con  = pick_value();
      ins.ridx = RIDX_W'($urandom_range(0, 3));
      ins.tgt  = TGT_W'($urandom_range(0, 1023));
      if (burst_left > 0) begin
         burst_left--;
         ins.op = burst_op;
         return ins;
      end
      k = $urandom_range(0, 99);
      if (k < 2) begin
         burst_op = OP_PUSH; burst_left = STACK_MAX + 3 - vm_depth;
         ins.op = OP_PUSH;
      end else if (k < 4) begin
         burst_op = OP_CALL; burst_left = CALLS_MAX + 2;
         ins.op = OP_CALL;
      end else if (k < 7) begin
         ins.op = OP_W'($urandom_range(23, 31));
      end else begin
         do ins.op = OP_W'($urandom_range(0, 22)); while (ins.op == OP_END);
         if (vm_depth < 2 && $urandom_range(0, 2) != 0)
            ins.op = $urandom_range(0, 1) ? OP_PUSH : OP_IN;
         else if (vm_depth > 40 && $urandom_range(0, 1) != 0)
            ins.op = $urandom_range(0, 1) ? OP_POP : OP_ADD;
      end
      return ins;
   endfunction

   // ---------------------------------------------------------------
   // Instruction sender
   // ---------------------------------------------------------------
   task automatic send_instr(instr_type ins, bit typed, outcome_type want);
      outcome_type got;
      req_bus.valid         <= 1'b1;
      req_bus.opcode        <= ins.op;
      req_bus.immediate     <= ins.imm;
      req_bus.reg_index     <= ins.ridx;
      req_bus.jump_target   <= ins.tgt;
      req_bus.console_value <= ins.con;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // beat accepted at this edge
      got = execute_instr(ins);
      pending_results.push_back(typed ? want : got);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   task automatic settle_and_config(logic [OPC_W-1:0] len);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      vm_length = len;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      instr_type ins;
      req_bus.valid = 1'b0;
      req_bus.opcode = '0;
      req_bus.immediate = '0;
      req_bus.reg_index = '0;
      req_bus.jump_target = '0;
      req_bus.console_value = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      settle_and_config(11'd0);

      foreach (directed[i]) send_instr(directed[i].ins, directed[i].typed, directed[i].want);

      // random phases, each configured with a program length first
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: settle_and_config(11'd1024);
            1: settle_and_config(11'($urandom_range(0, 1024)));
            2: settle_and_config(11'd0);
            default: settle_and_config(11'd1024);
         endcase
         if (phase == 1) long_hold_req = 300;   // back up the block
         if (phase == 3) quiet = 1;
         repeat (130) begin
            ins = random_instr();
            send_instr(ins, 0, '0);
         end
      end

      // finish the program, then poke the halted machine
      burst_left = 0;
      ins = random_instr();
      ins.op = OP_END;
      send_instr(ins, 0, '0);
      repeat (6) begin
         ins = random_instr();
         send_instr(ins, 0, '0);
      end
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   // ---------------------------------------------------------------
   // Result receiver and checker
   // ---------------------------------------------------------------
   initial begin
      outcome_type want;
      int stall;
      int hold;
      stall = 0;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               $error("result beat with nothing expected");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.next_pc !== want.npc) begin
                  $error("next_pc exp %0d got %0d", want.npc, rsp_bus.next_pc);
                  fail_count++;
               end
               if (rsp_bus.print_value !== want.pval) begin
                  $error("print_value exp %h got %h", want.pval, rsp_bus.print_value);
                  fail_count++;
               end
               if (rsp_bus.print_valid !== want.pvalid) begin
                  $error("print_valid exp %b got %b", want.pvalid, rsp_bus.print_valid);
                  fail_count++;
               end
               if (rsp_bus.halted !== want.halted) begin
                  $error("halted exp %b got %b", want.halted, rsp_bus.halted);
                  fail_count++;
               end
               if (rsp_bus.error_code !== want.err) begin
                  $error("error_code exp %0d got %0d", want.err, rsp_bus.error_code);
                  fail_count++;
               end
            end
         end
         if (long_hold_req > 0) begin
            hold = long_hold_req;
            long_hold_req = 0;
         end
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else if (quiet) begin
            rsp_bus.ready <= 1'b1;
         end else if (stall > 0) begin
            stall--;
            rsp_bus.ready <= 1'b0;
         end else if ($urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 14) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog
   int cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("testbench failed");
         $finish;
      end
   end

endmodule

// ===== filelist.f =====
hdl/smx_pkg.sv
hdl/smx_if.sv
hdl/smx_data_ram.sv
hdl/smx_divider.sv
hdl/stack_machine_execute_unit.sv
bench/testbench.sv
